>>> rtl/b64sc_pkg.sv
// Shared types, constants and alphabet functions for the Base64 stream codec.
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  // Most result items that one input item can cause.
  localparam int unsigned RES_MAX = 4;

  // Depth of the job queue between front and back; a power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Padding character '='.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Mode register codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Pending bit count: bits waiting minus the group size.
  typedef logic signed [4:0] pend_t;

  localparam pend_t P_M2 = -5'sd2;
  localparam pend_t P_M4 = -5'sd4;
  localparam pend_t P_M6 = -5'sd6;
  localparam pend_t P_M8 = -5'sd8;

  localparam pend_t ENC_START = P_M6;
  localparam pend_t DEC_START = P_M8;

  // One accepted item's worth of results, as handed from front to back.
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [1:0]              count_m1;
    logic                    data_valid;
    logic                    is_last;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  // Result of looking a character up in the alphabet.
  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } dec_t;

  // Maps a 6-bit group to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h47 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'h04;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Maps a character to its 6-bit value; hit is low outside the alphabet.
  function automatic dec_t dec_value(input logic [7:0] c);
    dec_t r;
    r.hit = 1'b1;
    if (c inside {[8'h41:8'h5A]}) begin
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.value = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.value = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.hit   = 1'b0;
      r.value = 6'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/b64sc_front.sv
// Front end: accepts items, keeps the bit stream state and builds result jobs.
`timescale 1ns / 1ps
`default_nettype none

module b64sc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_mode,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_end_of_message,
  input  wire b64sc_pkg::q_status_t  q_st,
  output logic                       push,
  output b64sc_pkg::job_t            job
);

  logic                 mode_r;
  logic [5:0]           acc_r;
  logic [11:0]          acc_nxt;
  b64sc_pkg::pend_t     pend_r;
  b64sc_pkg::pend_t     pend_nxt;
  b64sc_pkg::dec_t      dv;
  logic                 has_res;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_st.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && has_res;

  always_comb begin
    job      = '0;
    has_res  = 1'b0;
    acc_nxt  = {6'd0, acc_r};
    pend_nxt = pend_r;
    dv       = b64sc_pkg::dec_value(in_data_byte);
    job.is_last    = in_end_of_message;
    job.data_valid = 1'b1;
    if (mode_r == b64sc_pkg::MODE_ENCODE) begin
      acc_nxt = {acc_r[3:0], in_data_byte};
      has_res = 1'b1;
      case (pend_r)
        b64sc_pkg::P_M4: begin
          job.bytes[0] = b64sc_pkg::enc_char(acc_nxt[9:4]);
          pend_nxt     = b64sc_pkg::P_M2;
          if (in_end_of_message) begin
            job.bytes[1] = b64sc_pkg::enc_char({acc_nxt[3:0], 2'b00});
            job.bytes[2] = b64sc_pkg::PAD_CHAR;
            job.count_m1 = 2'd2;
          end
        end
        b64sc_pkg::P_M2: begin
          job.bytes[0] = b64sc_pkg::enc_char(acc_nxt[11:6]);
          job.bytes[1] = b64sc_pkg::enc_char(acc_nxt[5:0]);
          job.count_m1 = 2'd1;
          pend_nxt     = b64sc_pkg::P_M6;
        end
        default: begin
          job.bytes[0] = b64sc_pkg::enc_char(acc_nxt[7:2]);
          pend_nxt     = b64sc_pkg::P_M4;
          if (in_end_of_message) begin
            job.bytes[1] = b64sc_pkg::enc_char({acc_nxt[1:0], 4'b0000});
            job.bytes[2] = b64sc_pkg::PAD_CHAR;
            job.bytes[3] = b64sc_pkg::PAD_CHAR;
            job.count_m1 = 2'd3;
          end
        end
      endcase
    end else begin
      if (dv.hit) begin
        acc_nxt = {acc_r, dv.value};
        case (pend_r)
          b64sc_pkg::P_M8: begin
            pend_nxt = b64sc_pkg::P_M2;
          end
          b64sc_pkg::P_M2: begin
            job.bytes[0] = acc_nxt[11:4];
            has_res      = 1'b1;
            pend_nxt     = b64sc_pkg::P_M4;
          end
          b64sc_pkg::P_M4: begin
            job.bytes[0] = acc_nxt[9:2];
            has_res      = 1'b1;
            pend_nxt     = b64sc_pkg::P_M6;
          end
          default: begin
            job.bytes[0] = acc_nxt[7:0];
            has_res      = 1'b1;
            pend_nxt     = b64sc_pkg::P_M8;
          end
        endcase
      end
      // A last character that completes no byte still closes the message.
      if (in_end_of_message && !has_res) begin
        has_res        = 1'b1;
        job.data_valid = 1'b0;
      end
    end
    if (in_end_of_message) begin
      acc_nxt  = '0;
      pend_nxt = (mode_r == b64sc_pkg::MODE_DECODE) ? b64sc_pkg::DEC_START
                                                    : b64sc_pkg::ENC_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64sc_pkg::MODE_ENCODE;
      acc_r  <= '0;
      pend_r <= b64sc_pkg::ENC_START;
    end else if (cfg_valid) begin
      mode_r <= cfg_mode;
      acc_r  <= '0;
      pend_r <= (cfg_mode == b64sc_pkg::MODE_DECODE) ? b64sc_pkg::DEC_START
                                                     : b64sc_pkg::ENC_START;
    end else if (accept) begin
      acc_r  <= acc_nxt[5:0];
      pend_r <= pend_nxt;
    end
  end

  a_enc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == b64sc_pkg::MODE_ENCODE) |->
      (pend_r == b64sc_pkg::P_M6 || pend_r == b64sc_pkg::P_M4 ||
       pend_r == b64sc_pkg::P_M2))
    else $error("encode phase left its legal set");

  a_dec_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == b64sc_pkg::MODE_DECODE) |->
      (pend_r == b64sc_pkg::P_M8 || pend_r == b64sc_pkg::P_M6 ||
       pend_r == b64sc_pkg::P_M4 || pend_r == b64sc_pkg::P_M2))
    else $error("decode phase left its legal set");

endmodule

`default_nettype wire

>>> rtl/b64sc_queue.sv
// Short job queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none

module b64sc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire b64sc_pkg::job_t      wr_job,
  input  wire logic                 pop,
  output b64sc_pkg::job_t           head,
  output b64sc_pkg::q_status_t      q_st
);

  b64sc_pkg::job_t                   mem_r [b64sc_pkg::QDEPTH];
  logic [b64sc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [b64sc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [b64sc_pkg::QPTR_W:0]        count_r;
  logic [b64sc_pkg::QPTR_W:0]        count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_st.not_empty = (count_r != '0);
  assign q_st.full    = (count_r == (b64sc_pkg::QPTR_W + 1)'(b64sc_pkg::QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (b64sc_pkg::QPTR_W + 1)'(b64sc_pkg::QDEPTH))
    else $error("job queue count beyond its depth");

endmodule

`default_nettype wire

>>> rtl/b64sc_back.sv
// Back end: walks the head job one result at a time into the output register.
`timescale 1ns / 1ps
`default_nettype none

module b64sc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire b64sc_pkg::job_t      head,
  input  wire b64sc_pkg::q_status_t q_st,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_out_byte,
  output logic                      out_out_valid,
  output logic                      out_out_last
);

  logic [1:0] sel_r;
  logic [1:0] sel_nxt;
  logic       full_r;
  logic [7:0] byte_r;
  logic       dv_r;
  logic       last_r;
  logic       load;
  logic       end_of_job;

  assign load       = q_st.not_empty && (!full_r || out_ready);
  assign end_of_job = (sel_r == head.count_m1);
  assign pop        = load && end_of_job;

  always_comb begin
    sel_nxt = sel_r;
    if (load) begin
      sel_nxt = end_of_job ? 2'd0 : sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      sel_r  <= 2'd0;
    end else begin
      if (load) begin
        full_r <= 1'b1;
      end else if (out_ready) begin
        full_r <= 1'b0;
      end
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[sel_r];
      dv_r   <= head.data_valid;
      last_r <= head.is_last && end_of_job;
    end
  end

  assign out_valid     = full_r;
  assign out_out_byte  = byte_r;
  assign out_out_valid = dv_r;
  assign out_out_last  = last_r;

  a_sel_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.not_empty |-> (sel_r <= head.count_m1))
    else $error("result select ran past the head job");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !dv_r) |-> last_r)
    else $error("empty marker result not flagged last");

endmodule

`default_nettype wire

>>> rtl/base64_stream_codec_core.sv
// Top level of the Base64 stream codec: front end, job queue and output serializer.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 codec with the standard alphabet.
// The cfg channel writes the one mode bit (0 encode, 1 decode); a write also
// restarts the stream state. cfg ready is always high, so writes belong
// between messages, while the block is idle.
// The in channel carries one item per handshake: a byte or character plus an
// end-of-message flag. The out channel carries one result item per handshake:
// a character or byte, a data flag (low only on the empty end marker of
// decode) and a last flag on the final result of each message.
// The front end updates the bit accumulator and builds all results of an item
// in the cycle it accepts the item, and pushes them as one job into a two-entry
// queue. The back end sends one result per cycle while the receiver takes them,
// from the queue head through a registered output stage, so an item's first
// result is offered once its job is written into the queue and then loaded into
// the output register. The output side sets the rate: one result per cycle while
// the receiver is ready, so an encode item yields one to four results (about 1.33
// on average over full groups) and a decode item at most one. Items are taken
// while earlier results are still being sent. When the receiver stalls, the output
// register holds, the queue fills and in ready drops once both entries are occupied.
// Reset selects encode mode and empties the queue and the output stage.
module base64_stream_codec_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_mode,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_out_valid,
  output logic            out_out_last
);

  // Job handoff between the front end and the queue.
  b64sc_pkg::job_t      wr_job;
  logic                 push;

  // Queue head for the back end, and status seen by both ends.
  b64sc_pkg::job_t      head;
  b64sc_pkg::q_status_t q_st;
  logic                 pop;

  b64sc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_mode          (cfg_mode),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_st              (q_st),
    .push              (push),
    .job               (wr_job)
  );

  b64sc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .q_st   (q_st)
  );

  // The back end drains the head job in order, one result per cycle unless stalled.
  b64sc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_st          (q_st),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_out_valid (out_out_valid),
    .out_out_last  (out_out_last)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the Base64 stream codec core.
`timescale 1ns / 1ps

module tb;

  // The standard alphabet, first character in the top byte.
  localparam logic [511:0] ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 120;

  typedef struct {
    logic [7:0] data;
    logic       eom;
  } tx_item_t;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_ready = 1'b0;
  wire logic       cfg_ready;
  wire logic       in_ready;
  wire logic       out_valid;
  wire logic [7:0] out_out_byte;
  wire logic       out_out_valid;
  wire logic       out_out_last;

  // Items waiting to be offered, and results the codec still owes.
  tx_item_t tx_items[$];
  result_t  want_results[$];

  // Own copy of the codec state.
  logic        model_mode = b64sc_pkg::MODE_ENCODE;
  logic [15:0] model_acc = 16'h0000;
  int          model_pend = -6;
  logic [1:0]  model_chars = 2'd0;

  int   errors = 0;
  int   stall_cycles = 0;
  int   hold_cnt = 0;
  logic steady = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  base64_stream_codec_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_mode          (cfg_mode),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_out_byte      (out_out_byte),
    .out_out_valid     (out_out_valid),
    .out_out_last      (out_out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return ALPHA[8 * (63 - int'(v)) +: 8];
  endfunction

  // Position of a character in the alphabet, or -1 when it is not in it.
  function automatic int alpha_index(input logic [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (alpha_char(6'(i)) == c) return i;
    end
    return -1;
  endfunction

  task automatic codec_restart();
    model_acc   = 16'h0000;
    model_pend  = (model_mode == b64sc_pkg::MODE_DECODE) ? -8 : -6;
    model_chars = 2'd0;
  endtask

  // Works out the results of one accepted item and queues them.
  task automatic codec_step(input logic [7:0] d, input logic eom);
    result_t     batch[4];
    int          n;
    int          v;
    int          k;
    logic [23:0] wide;
    n = 0;
    if (model_mode == b64sc_pkg::MODE_ENCODE) begin
      model_acc = {model_acc[7:0], d};
      model_pend += 8;
      while (model_pend >= 0) begin
        batch[n] = '{alpha_char(6'(model_acc >> model_pend)), 1'b1, 1'b0};
        n++;
        model_chars++;
        model_pend -= 6;
      end
      if (eom) begin
        // A partial group is padded with zero bits on the right.
        if (model_pend > -6) begin
          wide = {model_acc, 8'h00};
          batch[n] = '{alpha_char(6'(wide >> (model_pend + 8))), 1'b1, 1'b0};
          n++;
          model_chars++;
        end
        while (model_chars != 2'd0 && n < 4) begin
          batch[n] = '{b64sc_pkg::PAD_CHAR, 1'b1, 1'b0};
          n++;
          model_chars++;
        end
        batch[n - 1].last = 1'b1;
        codec_restart();
      end
    end else begin
      v = alpha_index(d);
      if (v >= 0) begin
        model_acc = {model_acc[9:0], 6'(v)};
        model_pend += 6;
        if (model_pend >= 0) begin
          batch[n] = '{8'(model_acc >> model_pend), 1'b1, 1'b0};
          n++;
          model_pend -= 8;
        end
      end
      if (eom) begin
        // A final character that completes no byte yields an empty marker.
        if (n > 0) batch[0].last = 1'b1;
        else begin
          batch[n] = '{8'h00, 1'b0, 1'b1};
          n++;
        end
        codec_restart();
      end
    end
    for (k = 0; k < n; k++) want_results.insert(want_results.size(), batch[k]);
  endtask

  // Sender: offers the next pending item, idling at random.
  always @(posedge clk) begin : drive_items
    tx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_items.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        nxt = tx_items.pop_front();
        in_valid          <= 1'b1;
        in_data_byte      <= nxt.data;
        in_end_of_message <= nxt.eom;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the codec up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // Monitor: tracks config writes and accepted items, checks every result.
  always @(posedge clk) begin : watch_ports
    result_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        model_mode = cfg_mode;
        codec_restart();
      end
      if (in_valid && in_ready) codec_step(in_data_byte, in_end_of_message);
      if (out_valid && out_ready) begin
        if (want_results.size() == 0) begin
          $error("unexpected result: out_byte %0h out_valid %0b out_last %0b",
                 out_out_byte, out_out_valid, out_out_last);
          errors++;
        end else begin
          exp_r = want_results.pop_front();
          if (out_out_byte !== exp_r.data) begin
            $error("out_byte: expected %0h, got %0h", exp_r.data, out_out_byte);
            errors++;
          end
          if (out_out_valid !== exp_r.valid) begin
            $error("out_valid: expected %0b, got %0b", exp_r.valid, out_out_valid);
            errors++;
          end
          if (out_out_last !== exp_r.last) begin
            $error("out_last: expected %0b, got %0b", exp_r.last, out_out_last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("base64_stream_codec_core test failed");
        $finish;
      end
    end
  end

  task automatic send(input logic [7:0] d, input logic eom);
    tx_item_t it;
    it.data = d;
    it.eom  = eom;
    tx_items.insert(tx_items.size(), it);
  endtask

  // Waits until every item is taken and every result has come back.
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || want_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int         phase;
    int         phase_items;
    int         random_items;
    int         i;
    int         nchar;
    int         pads;
    logic       paused;
    logic [7:0] msg[$];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Encode: one, two and three byte messages, field extremes included.
    set_mode(b64sc_pkg::MODE_ENCODE);
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send(8'h4D, 1'b0);
    send(8'h61, 1'b0);
    send(8'h6E, 1'b1);

    // Decode: a full quad, padding that ends on an empty marker, skipped
    // characters and the two symbol characters.
    wait_idle(10);
    set_mode(b64sc_pkg::MODE_DECODE);
    send("T", 1'b0);
    send("W", 1'b0);
    send("F", 1'b0);
    send("u", 1'b1);
    send("/", 1'b0);
    send("w", 1'b0);
    send("=", 1'b0);
    send("=", 1'b1);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h0A, 1'b0);
    send("+", 1'b0);
    send("/", 1'b0);
    send("A", 1'b0);
    send("A", 1'b1);

    // A message cut short by a mode write must leave no trace.
    send("Q", 1'b0);
    send("U", 1'b0);
    wait_idle(10);

    phase = 0;
    random_items = 0;
    paused = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle(10);
      set_mode(phase[0] ? b64sc_pkg::MODE_DECODE : b64sc_pkg::MODE_ENCODE);
      steady = (phase == 1);
      if (phase == 2) hold_go = 1'b1;
      phase_items = 0;
      while (phase_items < 30) begin
        // Once, the sender stops until everything owed has drained.
        if (phase == 3 && !paused && phase_items >= 15) begin
          wait_idle(0);
          paused = 1'b1;
        end
        msg.delete();
        if (!phase[0]) begin
          nchar = $urandom_range(1, 7);
          for (i = 0; i < nchar; i++) msg.insert(msg.size(), 8'($urandom_range(255)));
          phase_items += nchar;
        end else begin
          // Mostly alphabet text, some noise, optional padding and tail noise.
          nchar = $urandom_range(1, 8);
          for (i = 0; i < nchar; i++) begin
            if ($urandom_range(99) < 15) msg.insert(msg.size(), 8'($urandom_range(255)));
            msg.insert(msg.size(), alpha_char(6'($urandom_range(63))));
          end
          pads = ($urandom_range(99) < 40) ? $urandom_range(1, 2) : 0;
          for (i = 0; i < pads; i++) msg.insert(msg.size(), b64sc_pkg::PAD_CHAR);
          if ($urandom_range(99) < 15) msg.insert(msg.size(), 8'($urandom_range(255)));
          phase_items += nchar;
        end
        for (i = 0; i < msg.size(); i++) send(msg[i], i == msg.size() - 1);
      end
      random_items += phase_items;
      phase++;
    end

    wait_idle(0);
    repeat (20) @(posedge clk);
    if (errors == 0 && want_results.size() == 0) begin
      $display("base64_stream_codec_core test passed");
    end else begin
      $display("base64_stream_codec_core test failed");
    end
    $finish;
  end

endmodule
